[design/pfa_pkg.sv]
package pfa_pkg;

  // Field widths of the request and response words.
  localparam int FUNC_W   = 2;
  localparam int DIR_AW   = 10;
  localparam int AMOUNT_W = 32;
  localparam int FRAME_NW = 10;
  localparam int COUNT_W  = 11;

  // Page directory geometry and entry layout.
  localparam int DIR_ENTRIES  = 1 << DIR_AW;
  localparam int ENTRY_W      = 14;
  localparam int ENTRY_FLAG_W = 4;
  localparam int PAGE_SHIFT   = 22;

  localparam logic [DIR_AW-1:0] KERNEL_HIGH_IDX = 10'h300;
  localparam logic [DIR_AW-1:0] LAST_DIR_IDX    = 10'h3FF;

  localparam logic [ENTRY_FLAG_W-1:0] E_PRESENT = 4'b0001;
  localparam logic [ENTRY_FLAG_W-1:0] E_WRITE   = 4'b0010;
  localparam logic [ENTRY_FLAG_W-1:0] E_USER    = 4'b0100;
  localparam logic [ENTRY_FLAG_W-1:0] E_LARGE   = 4'b1000;

  localparam logic [ENTRY_W-1:0] KERNEL_ENTRY =
    {{FRAME_NW{1'b0}}, E_PRESENT | E_WRITE | E_LARGE};
  localparam logic [ENTRY_FLAG_W-1:0] USER_FLAGS = E_PRESENT | E_WRITE | E_USER | E_LARGE;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Function codes as they arrive on the request word.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = 1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CHECK,
    OP_NONE
  } pfa_op_t;

  // Classified command. For a check, need holds the number of whole
  // frames the requested byte count occupies, rounded up.
  typedef struct packed {
    pfa_op_t             op;
    logic [DIR_AW-1:0]   vidx;
    logic [COUNT_W-1:0]  need;
  } pfa_cmd_t;

endpackage

[design/pfa_if.sv]
interface pfa_req_if;
  import pfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [DIR_AW-1:0]   virtual_index;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output func, output virtual_index, output amount,
                  input ready);
  modport sink   (input valid, input func, input virtual_index, input amount,
                  output ready);
endinterface

interface pfa_rsp_if;
  import pfa_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [FRAME_NW-1:0] frame_number;
  logic [COUNT_W-1:0]  free_frames;

  modport source (output valid, output ok, output frame_number, output free_frames,
                  input ready);
  modport sink   (input valid, input ok, input frame_number, input free_frames,
                  output ready);
endinterface

[design/pfa_front.sv]
module pfa_front (
  input  logic             clk,
  input  logic             rst,
  pfa_req_if.sink          req,
  input  logic             clearing,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output pfa_pkg::pfa_cmd_t cmd
);
  import pfa_pkg::*;

  pfa_cmd_t                 queue [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]      wr_ptr;
  logic [QUEUE_PW-1:0]      rd_ptr;
  logic [QUEUE_PW:0]        fill;
  pfa_cmd_t                 cls;
  logic                     push;
  logic                     pop;

  // Classify the incoming word and turn the byte count into a frame count.
  always_comb begin
    case (req.func)
      FUNC_ALLOC: cls.op = OP_ALLOC;
      FUNC_FREE:  cls.op = OP_FREE;
      FUNC_CHECK: cls.op = OP_CHECK;
      default:    cls.op = OP_NONE;
    endcase
    cls.vidx = req.virtual_index;
    cls.need = COUNT_W'(req.amount[AMOUNT_W-1:PAGE_SHIFT]) +
               COUNT_W'(|req.amount[PAGE_SHIFT-1:0]);
  end

  assign req.ready = !clearing && (fill != (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= cls;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[design/pfa_back.sv]
module pfa_back #(
  parameter int FRAME_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  pfa_pkg::pfa_cmd_t cmd,
  output logic              clearing,
  pfa_rsp_if.source         rsp
);
  import pfa_pkg::*;

  localparam int FW = $clog2(FRAME_COUNT);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                   state;
  logic [DIR_AW-1:0]        clr_addr;
  pfa_cmd_t                 cur;
  logic [ENTRY_W-1:0]       dir_mem [DIR_ENTRIES];
  logic [ENTRY_W-1:0]       rd_data;
  logic [FRAME_COUNT-1:0]   frame_used;
  logic [COUNT_W-1:0]       free_count;
  logic [FW-1:0]            lowest_free;
  logic                     any_free;
  logic [FW-1:0]            scan_idx;
  logic                     scan_found;

  logic                     out_free;
  logic                     fire;
  logic                     rd_en;
  logic                     dir_we;
  logic [DIR_AW-1:0]        dir_waddr;
  logic [ENTRY_W-1:0]       dir_wdata;
  logic [FRAME_NW-1:0]      ent_frame;
  logic                     ent_in_range;
  logic                     ent_used;
  logic                     res_ok;
  logic [FRAME_NW-1:0]      res_frame;
  logic                     do_set;
  logic                     do_clr;
  logic [FW-1:0]            bit_idx;
  logic [COUNT_W-1:0]       count_next;

  assign clearing  = (state == S_CLEAR);
  assign cmd_ready = (state == S_IDLE);
  assign rd_en     = cmd_ready && cmd_valid;
  assign out_free  = !rsp.valid || rsp.ready;
  assign fire      = (state == S_EXEC) && out_free;

  // Lowest free frame, registered so the search stays off the execute path.
  always_comb begin
    scan_idx   = '0;
    scan_found = 1'b0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!frame_used[i]) begin
        scan_idx   = FW'(i);
        scan_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_free <= 1'b0;
    end else begin
      any_free <= scan_found;
    end
    lowest_free <= scan_idx;
  end

  // Decode the directory entry that was read and work out the result.
  always_comb begin
    ent_frame    = rd_data[ENTRY_W-1:ENTRY_FLAG_W];
    ent_in_range = (COUNT_W'(ent_frame) < COUNT_W'(FRAME_COUNT));
    ent_used     = ent_in_range && frame_used[ent_frame[FW-1:0]];
    res_ok       = 1'b0;
    res_frame    = '0;
    do_set       = 1'b0;
    do_clr       = 1'b0;
    bit_idx      = lowest_free;
    count_next   = free_count;
    case (cur.op)
      OP_ALLOC: begin
        if (any_free) begin
          res_ok    = 1'b1;
          res_frame = FRAME_NW'(lowest_free);
          do_set    = 1'b1;
          if (free_count != '0) begin
            count_next = free_count - 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (rd_data[0] && ent_used) begin
          res_ok    = 1'b1;
          res_frame = ent_frame;
          do_clr    = 1'b1;
          bit_idx   = ent_frame[FW-1:0];
          if (free_count != COUNT_MAX) begin
            count_next = free_count + 1'b1;
          end
        end
      end
      OP_CHECK: begin
        res_ok = (free_count >= cur.need);
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // One write port: the clearing sweep, or the write-back of an executed command.
  always_comb begin
    if (state == S_CLEAR) begin
      dir_we    = 1'b1;
      dir_waddr = clr_addr;
      dir_wdata = (clr_addr == '0 || clr_addr == KERNEL_HIGH_IDX) ? KERNEL_ENTRY : '0;
    end else begin
      dir_we    = fire && (do_set || do_clr);
      dir_waddr = cur.vidx;
      dir_wdata = do_set ? {FRAME_NW'(lowest_free), USER_FLAGS} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (rd_en) begin
      rd_data <= dir_mem[cmd.vidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      rsp.valid  <= 1'b0;
      frame_used <= FRAME_COUNT'(1);
      free_count <= COUNT_W'(FRAME_COUNT - 1);
    end else begin
      if (rsp.valid && rsp.ready && !fire) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_DIR_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.ok           <= res_ok;
            rsp.frame_number <= res_frame;
            rsp.free_frames  <= count_next;
            free_count       <= count_next;
            if (do_set) begin
              frame_used[bit_idx] <= 1'b1;
            end
            if (do_clr) begin
              frame_used[bit_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/page_frame_allocator.sv]
// A request word is held in the front queue, then registered into the back's command and entry
// read, and then into the response word. The back takes no new command until the last one has
// executed: it reads the directory entry on taking a command and writes it back on executing it.
// Reset: synchronous and active high. The directory is then swept, one entry per cycle,
// through all 1024 entries, during which no request word is accepted.
module page_frame_allocator #(
  parameter int FRAME_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp
);
  import pfa_pkg::*;

  // The front accepts request words, decodes the function code and, for a
  // space check, converts the byte count into a whole number of 4 MiB frames
  // rounded up. Classified commands wait in a two-entry queue, so the front
  // keeps taking words while the back is busy or its response is stalled.
  //
  // The back owns all state: the 1024-entry page directory (a memory with one
  // write and one registered read port), the frame-in-use bitmap and the free
  // count. It reads the directory entry on taking a command and resolves and writes
  // it back once the response is free. The lowest free frame is found by a priority
  // search whose result is registered, so it is always current by the time the next
  // command executes. After reset the back sweeps the directory to zero and places
  // the two kernel entries, and holds the front off while it does so.

  pfa_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_ready;
  logic     clearing;

  pfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pfa_back #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .clearing  (clearing),
    .rsp       (rsp)
  );

endmodule
